FILE: sv/narma_pkg.sv
// shared types, constants and the tanh table of the narma target generator
`default_nettype none

package narma_pkg;

   // sizes that follow from the history depth and the tanh table
   localparam int MAX_ORDER          = 64;
   localparam int TANH_TABLE_ENTRIES = 256;

   // fixed field widths
   localparam int SAMPLE_WIDTH  = 16;
   localparam int TARGET_WIDTH  = 16;
   localparam int SCALED_WIDTH  = 14;
   localparam int COEF_WIDTH    = 15;
   localparam int ORDER_FIELD_WIDTH = 7;
   localparam int CSR_DATA_WIDTH  = 15;
   localparam int CSR_INDEX_WIDTH = 2;

   // derived widths
   localparam int RING_WIDTH  = $clog2(MAX_ORDER);
   localparam int ORDER_WIDTH = $clog2(MAX_ORDER + 1);
   localparam int WSUM_WIDTH  = 16 + RING_WIDTH;
   localparam int ACC_WIDTH   = 46 + RING_WIDTH;
   localparam int ROUND_SHIFT = 28;
   localparam int VALUE_WIDTH = ACC_WIDTH - ROUND_SHIFT;
   localparam int Q_FRAC_BITS = 14;
   localparam int TANH_SPAN_BITS   = 16;
   localparam int TANH_INDEX_WIDTH = $clog2(TANH_TABLE_ENTRIES + 1);
   localparam int TANH_POS_WIDTH   = TANH_SPAN_BITS + TANH_INDEX_WIDTH;

   // arithmetic constants
   localparam int Q14_ONE          = 16384;
   localparam int TANH_FROM_ORDER  = 11;
   localparam int DELTA_LOW_ORDER  = 1638;
   localparam int DELTA_HIGH_ORDER = 164;
   localparam int MIN_ORDER        = 2;

   // delta with the rounding half folded in
   localparam logic [ACC_WIDTH-1:0] DELTA_LOW_ROUND =
      (ACC_WIDTH'(DELTA_LOW_ORDER) << ROUND_SHIFT) + (ACC_WIDTH'(1) << (ROUND_SHIFT - 1));
   localparam logic [ACC_WIDTH-1:0] DELTA_HIGH_ROUND =
      (ACC_WIDTH'(DELTA_HIGH_ORDER) << ROUND_SHIFT) + (ACC_WIDTH'(1) << (ROUND_SHIFT - 1));

   // register reset values
   localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = ORDER_WIDTH'(10);
   localparam logic [COEF_WIDTH-1:0]  ALPHA_RESET = COEF_WIDTH'(4915);
   localparam logic [COEF_WIDTH-1:0]  BETA_RESET  = COEF_WIDTH'(819);
   localparam logic [COEF_WIDTH-1:0]  GAMMA_RESET = COEF_WIDTH'(24576);

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ORDER = 2'd0,
      CSR_ALPHA = 2'd1,
      CSR_BETA  = 2'd2,
      CSR_GAMMA = 2'd3
   } csr_index_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [ORDER_WIDTH-1:0] order;
      logic [COEF_WIDTH-1:0]  alpha;
      logic [COEF_WIDTH-1:0]  beta;
      logic [COEF_WIDTH-1:0]  gamma;
      logic                   order_write;
   } cfg_type;

   // history memory access
   typedef struct packed {
      logic                          rd_en;
      logic [RING_WIDTH-1:0]         rd_addr;
      logic                          wr_en;
      logic [RING_WIDTH-1:0]         wr_addr;
      logic [SCALED_WIDTH-1:0]       wr_scaled;
      logic signed [TARGET_WIDTH-1:0] wr_target;
   } hist_req_type;

   typedef struct packed {
      logic [SCALED_WIDTH-1:0]        scaled;
      logic signed [TARGET_WIDTH-1:0] target;
   } hist_rsp_type;

   // tanh table, built at elaboration
   typedef logic [TARGET_WIDTH-1:0] tanh_table_type [0:TANH_TABLE_ENTRIES];

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   // restoring division, only used while the table is built
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // entry k is 16384*tanh(4k/E) as (1-w)/(1+w), w = exp(-k/E)^8 in Q.30
   function automatic tanh_table_type build_tanh_table();
      tanh_table_type tbl;
      logic [63:0] g;
      logic [63:0] term;
      logic [63:0] w;
      logic [63:0] num;
      logic [63:0] den;
      longint      sum;
      for (int k = 0; k <= TANH_TABLE_ENTRIES; k++) begin
         g    = udiv64(64'(k) << 30, 64'(TANH_TABLE_ENTRIES));
         term = Q30_ONE;
         sum  = longint'(Q30_ONE);
         for (int i = 1; i <= 20; i++) begin
            term = udiv64((term * g) >> 30, 64'(i));
            if (i[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         w = 64'(sum);
         for (int j = 0; j < 3; j++) begin
            w = (w * w + (Q30_ONE >> 1)) >> 30;
         end
         if (w > Q30_ONE) begin
            w = Q30_ONE;
         end
         num = (Q30_ONE - w) * 64'd32768 + (Q30_ONE + w);
         den = 64'd2 * (Q30_ONE + w);
         tbl[k] = TARGET_WIDTH'(udiv64(num, den));
      end
      return tbl;
   endfunction

   localparam tanh_table_type TANH_TABLE = build_tanh_table();

endpackage

`default_nettype wire

FILE: sv/narma_target_generator.sv
// narma target generator top level: sequencer, recurrence datapath and result register
//
// Takes one raw Q2.14 sample per req_ transfer (req_valid/req_ready) and returns one
// Q2.14 target per rsp_ transfer (rsp_valid/rsp_ready), in order. Coefficients and
// the order are to be written on the csr_ port only while the block is idle, which
// the block does not enforce; writing the order restarts the series. A transfer with
// req_last_in_series set ends the series after its own result.
// An item passes through the transfer, then history read and two multiply steps,
// the Q.42 sum, the tanh table lookup, and the writeback into the history memories.
// The recurrence on the previous target runs through all of them. The result is
// registered at the writeback.
// A new item may be taken while a result waits on rsp_; if the receiver still holds
// off when the next result is done, the block waits in writeback until rsp_ready.
// Synchronous reset clears the sequencer, series counters, window sum and the result
// valid flag and restores the default coefficients; the history memories are not
// cleared, since each entry is written before its value is used within a series.
`default_nettype none

module narma_target_generator (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_ready,
   input  wire logic signed [narma_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   input  wire logic                                      req_last_in_series,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output logic signed [narma_pkg::TARGET_WIDTH-1:0]      rsp_target_out,
   output logic                                           rsp_warming_up,
   input  wire logic                                      csr_write_en,
   input  wire logic [narma_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [narma_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_LOOK,
      ST_FIN
   } state_type;

   localparam int RING_W  = narma_pkg::RING_WIDTH;
   localparam int ORDER_W = narma_pkg::ORDER_WIDTH;
   localparam int ACC_W   = narma_pkg::ACC_WIDTH;
   localparam int WSUM_W  = narma_pkg::WSUM_WIDTH;
   localparam int TGT_W   = narma_pkg::TARGET_WIDTH;
   localparam int SCL_W   = narma_pkg::SCALED_WIDTH;
   localparam int COEF_W  = narma_pkg::COEF_WIDTH;
   localparam int SMP_W   = narma_pkg::SAMPLE_WIDTH;
   localparam int VAL_W   = narma_pkg::VALUE_WIDTH;
   localparam int PROD_W  = 2 * TGT_W;

   narma_pkg::cfg_type      cfg;
   narma_pkg::hist_req_type hist_req;
   narma_pkg::hist_rsp_type hist_rsp;

   state_type                   state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [TGT_W-1:0]     rsp_target_ff, rsp_target_in;
   logic                        rsp_warm_ff, rsp_warm_in;
   logic [ORDER_W-1:0]          samples_seen_ff, samples_seen_in;
   logic [RING_W-1:0]           ring_pos_ff, ring_pos_in;
   logic signed [WSUM_W-1:0]    wsum_ff, wsum_in;
   logic signed [TGT_W-1:0]     y_prev_ff, y_prev_in;
   logic [SCL_W-1:0]            scaled_ff, scaled_in;
   logic                        last_ff, last_in;
   logic                        warm_ff, warm_in;
   logic signed [PROD_W-1:0]    pa_ff, pa_in;
   logic signed [PROD_W-1:0]    pb_ff, pb_in;
   logic [COEF_W+SCL_W-1:0]     pg_ff, pg_in;
   logic [ACC_W-1:0]            pbw_ff, pbw_in;
   logic [COEF_W+2*SCL_W-1:0]   pgs_ff, pgs_in;
   logic signed [VAL_W-1:0]     v_ff, v_in;

   logic                        accept;
   logic                        fin_fire;
   logic                        tanh_on;
   logic signed [SMP_W-1:0]     u_clamped;
   logic [SMP_W:0]              u_offset;
   logic [RING_W+1:0]           old_sum;
   logic [RING_W-1:0]           old_addr;
   logic signed [PROD_W+WSUM_W-1:0] pbw_full;
   logic [ACC_W-1:0]            acc;
   logic [ACC_W-1:0]            delta_round;
   logic signed [TGT_W-1:0]     tanh_result;
   logic signed [TGT_W-1:0]     v_clipped;
   logic signed [TGT_W-1:0]     y_calc;
   logic signed [TGT_W-1:0]     y_final;

   narma_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   narma_history u_history (
      .clock (clock),
      .req   (hist_req),
      .rsp   (hist_rsp)
   );

   narma_tanh u_tanh (
      .clock  (clock),
      .load   (state_ff == ST_LOOK),
      .value  (v_ff),
      .result (tanh_result)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fin_fire  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign tanh_on   = int'(cfg.order) >= narma_pkg::TANH_FROM_ORDER;

   // input clamp and rescale to (u+1)/4
   always_comb begin
      if (req_sample_in > narma_pkg::Q14_ONE) begin
         u_clamped = SMP_W'(narma_pkg::Q14_ONE);
      end else if (req_sample_in < -narma_pkg::Q14_ONE) begin
         u_clamped = SMP_W'(-narma_pkg::Q14_ONE);
      end else begin
         u_clamped = req_sample_in;
      end
      u_offset = (SMP_W + 1)'(u_clamped) + (SMP_W + 1)'(narma_pkg::Q14_ONE);
   end

   // oldest slot of the window: ring position minus order, wrapped
   always_comb begin
      old_sum = (RING_W + 2)'(ring_pos_ff) + (RING_W + 2)'(narma_pkg::MAX_ORDER)
              - (RING_W + 2)'(cfg.order);
      if (int'(old_sum) >= narma_pkg::MAX_ORDER) begin
         old_addr = RING_W'(old_sum - (RING_W + 2)'(narma_pkg::MAX_ORDER));
      end else begin
         old_addr = RING_W'(old_sum);
      end
   end

   // multiply steps, one register after each
   always_comb begin
      pa_in    = $signed({1'b0, cfg.alpha}) * y_prev_ff;
      pb_in    = $signed({1'b0, cfg.beta}) * y_prev_ff;
      pg_in    = cfg.gamma * hist_rsp.scaled;
      pbw_full = pb_ff * wsum_ff;
      pbw_in   = pbw_full[ACC_W-1:0];
      pgs_in   = pg_ff * scaled_ff;
   end

   // Q.42 sum; the rounding half rides with delta, the top bits are the Q10.14 value
   always_comb begin
      delta_round = tanh_on ? narma_pkg::DELTA_HIGH_ROUND : narma_pkg::DELTA_LOW_ROUND;
      acc  = (ACC_W'(pa_ff) << narma_pkg::Q_FRAC_BITS) + pbw_ff + ACC_W'(pgs_ff)
           + delta_round;
      v_in = acc[ACC_W-1:narma_pkg::ROUND_SHIFT];
   end

   // final target: tanh or plain, clipped to one, zero while warming up
   always_comb begin
      if (v_ff > narma_pkg::Q14_ONE) begin
         v_clipped = TGT_W'(narma_pkg::Q14_ONE);
      end else if (v_ff < -narma_pkg::Q14_ONE) begin
         v_clipped = TGT_W'(-narma_pkg::Q14_ONE);
      end else begin
         v_clipped = v_ff[TGT_W-1:0];
      end
      y_calc  = tanh_on ? tanh_result : v_clipped;
      y_final = warm_ff ? '0 : y_calc;
   end

   // history access: read at transfer, write at writeback; never in the same cycle
   always_comb begin
      hist_req.rd_en     = accept;
      hist_req.rd_addr   = old_addr;
      hist_req.wr_en     = fin_fire;
      hist_req.wr_addr   = ring_pos_ff;
      hist_req.wr_scaled = scaled_ff;
      hist_req.wr_target = y_final;
   end

   // sequencer and next values
   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_target_in   = rsp_target_ff;
      rsp_warm_in     = rsp_warm_ff;
      samples_seen_in = samples_seen_ff;
      ring_pos_in     = ring_pos_ff;
      wsum_in         = wsum_ff;
      y_prev_in       = y_prev_ff;
      scaled_in       = scaled_ff;
      last_in         = last_ff;
      warm_in         = warm_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in  = ST_MUL1;
               scaled_in = u_offset[SCL_W+1:2];
               last_in   = req_last_in_series;
               warm_in   = samples_seen_ff < cfg.order;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_LOOK;
         ST_LOOK: state_in = ST_FIN;
         ST_FIN: begin
            if (fin_fire) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_target_in = y_final;
               rsp_warm_in   = warm_ff;
               y_prev_in     = y_final;
               if (warm_ff) begin
                  samples_seen_in = samples_seen_ff + 1'b1;
               end else begin
                  wsum_in = wsum_ff + WSUM_W'(y_final) - WSUM_W'(hist_rsp.target);
               end
               if (int'(ring_pos_ff) == narma_pkg::MAX_ORDER - 1) begin
                  ring_pos_in = '0;
               end else begin
                  ring_pos_in = ring_pos_ff + 1'b1;
               end
               if (last_ff) begin
                  samples_seen_in = '0;
                  wsum_in         = '0;
                  ring_pos_in     = '0;
               end
            end
         end
      endcase
      // series restart on an order write
      if (cfg.order_write) begin
         samples_seen_in = '0;
         wsum_in         = '0;
         ring_pos_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         samples_seen_ff <= '0;
         ring_pos_ff     <= '0;
         wsum_ff         <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         samples_seen_ff <= samples_seen_in;
         ring_pos_ff     <= ring_pos_in;
         wsum_ff         <= wsum_in;
      end
      rsp_target_ff <= rsp_target_in;
      rsp_warm_ff   <= rsp_warm_in;
      y_prev_ff     <= y_prev_in;
      scaled_ff     <= scaled_in;
      last_ff       <= last_in;
      warm_ff       <= warm_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      pg_ff         <= pg_in;
      pbw_ff        <= pbw_in;
      pgs_ff        <= pgs_in;
      v_ff          <= v_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_target_out = rsp_target_ff;
   assign rsp_warming_up = rsp_warm_ff;

endmodule

`default_nettype wire

FILE: sv/narma_csr.sv
// configuration registers of the narma target generator
`default_nettype none

module narma_csr (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write_en,
   input  wire logic [narma_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [narma_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output narma_pkg::cfg_type                           cfg
);

   logic [narma_pkg::ORDER_WIDTH-1:0] order_ff, order_in;
   logic [narma_pkg::COEF_WIDTH-1:0]  alpha_ff, alpha_in;
   logic [narma_pkg::COEF_WIDTH-1:0]  beta_ff, beta_in;
   logic [narma_pkg::COEF_WIDTH-1:0]  gamma_ff, gamma_in;
   logic [narma_pkg::ORDER_FIELD_WIDTH-1:0] order_raw;
   logic                              order_write;

   assign order_raw = csr_wdata[narma_pkg::ORDER_FIELD_WIDTH-1:0];

   // register decode, order held within its legal range
   always_comb begin
      order_in    = order_ff;
      alpha_in    = alpha_ff;
      beta_in     = beta_ff;
      gamma_in    = gamma_ff;
      order_write = 1'b0;
      if (csr_write_en) begin
         unique case (narma_pkg::csr_index_type'(csr_index))
            narma_pkg::CSR_ORDER: begin
               order_write = 1'b1;
               if (int'(order_raw) < narma_pkg::MIN_ORDER) begin
                  order_in = narma_pkg::ORDER_WIDTH'(narma_pkg::MIN_ORDER);
               end else if (int'(order_raw) > narma_pkg::MAX_ORDER) begin
                  order_in = narma_pkg::ORDER_WIDTH'(narma_pkg::MAX_ORDER);
               end else begin
                  order_in = narma_pkg::ORDER_WIDTH'(order_raw);
               end
            end
            narma_pkg::CSR_ALPHA: alpha_in = csr_wdata[narma_pkg::COEF_WIDTH-1:0];
            narma_pkg::CSR_BETA:  beta_in  = csr_wdata[narma_pkg::COEF_WIDTH-1:0];
            narma_pkg::CSR_GAMMA: gamma_in = csr_wdata[narma_pkg::COEF_WIDTH-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= narma_pkg::ORDER_RESET;
         alpha_ff <= narma_pkg::ALPHA_RESET;
         beta_ff  <= narma_pkg::BETA_RESET;
         gamma_ff <= narma_pkg::GAMMA_RESET;
      end else begin
         order_ff <= order_in;
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
         gamma_ff <= gamma_in;
      end
   end

   assign cfg.order       = order_ff;
   assign cfg.alpha       = alpha_ff;
   assign cfg.beta        = beta_ff;
   assign cfg.gamma       = gamma_ff;
   assign cfg.order_write = order_write;

endmodule

`default_nettype wire

FILE: sv/narma_history.sv
// input and target history rings, one synchronous memory each
`default_nettype none

module narma_history (
   input  wire logic                   clock,
   input  wire narma_pkg::hist_req_type req,
   output narma_pkg::hist_rsp_type     rsp
);

   logic [narma_pkg::SCALED_WIDTH-1:0]        scaled_ram [0:narma_pkg::MAX_ORDER-1];
   logic signed [narma_pkg::TARGET_WIDTH-1:0] target_ram [0:narma_pkg::MAX_ORDER-1];
   logic [narma_pkg::SCALED_WIDTH-1:0]        rd_scaled_ff;
   logic signed [narma_pkg::TARGET_WIDTH-1:0] rd_target_ff;

   // write at the ring position, registered read at the oldest slot
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         scaled_ram[req.wr_addr] <= req.wr_scaled;
         target_ram[req.wr_addr] <= req.wr_target;
      end
      if (req.rd_en) begin
         rd_scaled_ff <= scaled_ram[req.rd_addr];
         rd_target_ff <= target_ram[req.rd_addr];
      end
   end

   assign rsp.scaled = rd_scaled_ff;
   assign rsp.target = rd_target_ff;

endmodule

`default_nettype wire

FILE: sv/narma_tanh.sv
// table tanh: registered lookup of two neighbors, then linear interpolation
`default_nettype none

module narma_tanh (
   input  wire logic                                        clock,
   input  wire logic                                        load,
   input  wire logic signed [narma_pkg::VALUE_WIDTH-1:0]    value,
   output logic signed [narma_pkg::TARGET_WIDTH-1:0]        result
);

   logic [narma_pkg::VALUE_WIDTH-1:0]      mag;
   logic                                   saturate;
   logic [narma_pkg::TANH_POS_WIDTH-1:0]   pos_t;
   logic [narma_pkg::TANH_INDEX_WIDTH-1:0] idx_lo;
   logic [narma_pkg::TANH_INDEX_WIDTH-1:0] idx_hi;
   logic [narma_pkg::TARGET_WIDTH-1:0]     lo;
   logic [narma_pkg::TARGET_WIDTH-1:0]     hi;
   logic [narma_pkg::TARGET_WIDTH-1:0]     lo_ff, lo_in;
   logic [narma_pkg::TARGET_WIDTH-1:0]     diff_ff, diff_in;
   logic [narma_pkg::TANH_SPAN_BITS-1:0]   frac_ff;
   logic                                   neg_ff;
   logic [31:0]                            interp;
   logic [narma_pkg::TARGET_WIDTH-1:0]     mag_out;

   // magnitude and table position
   always_comb begin
      mag = value[narma_pkg::VALUE_WIDTH-1] ? narma_pkg::VALUE_WIDTH'(-value)
                                            : narma_pkg::VALUE_WIDTH'(value);
      saturate = |mag[narma_pkg::VALUE_WIDTH-1:narma_pkg::TANH_SPAN_BITS];
      pos_t  = narma_pkg::TANH_POS_WIDTH'(mag[narma_pkg::TANH_SPAN_BITS-1:0])
             * narma_pkg::TANH_POS_WIDTH'(narma_pkg::TANH_TABLE_ENTRIES);
      idx_lo = pos_t[narma_pkg::TANH_POS_WIDTH-1:narma_pkg::TANH_SPAN_BITS];
      idx_hi = idx_lo + 1'b1;
      lo     = narma_pkg::TANH_TABLE[idx_lo];
      hi     = narma_pkg::TANH_TABLE[idx_hi];
   end

   // saturated inputs take the last entry flat
   always_comb begin
      if (saturate) begin
         lo_in   = narma_pkg::TANH_TABLE[narma_pkg::TANH_TABLE_ENTRIES];
         diff_in = '0;
      end else begin
         lo_in   = lo;
         diff_in = (hi > lo) ? hi - lo : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff   <= lo_in;
         diff_ff <= diff_in;
         frac_ff <= pos_t[narma_pkg::TANH_SPAN_BITS-1:0];
         neg_ff  <= value[narma_pkg::VALUE_WIDTH-1];
      end
   end

   // interpolation rounded half up, sign restored last
   always_comb begin
      interp  = 32'(diff_ff) * 32'(frac_ff) + 32'd32768;
      mag_out = lo_ff + interp[31:16];
      result  = neg_ff ? -$signed(mag_out) : $signed(mag_out);
   end

endmodule

`default_nettype wire

FILE: sv/narma_checker.sv
// port-level checks of the narma target generator, bound to the top level
`default_nettype none

module narma_checker (
   input wire logic                                      clock,
   input wire logic                                      reset,
   input wire logic                                      req_valid,
   input wire logic                                      req_ready,
   input wire logic                                      rsp_valid,
   input wire logic                                      rsp_ready,
   input wire logic signed [narma_pkg::TARGET_WIDTH-1:0] rsp_target_out,
   input wire logic                                      rsp_warming_up
);

   // a stalled result holds
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target_out)
                                  && $stable(rsp_warming_up))
      else $error("result changed while stalled");

   // warm-up results are zero
   warm_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_warming_up |-> rsp_target_out == '0)
      else $error("nonzero target during warm-up");

   // target clipped to one
   target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_target_out <= 16'sd16384) && (rsp_target_out >= -16'sd16384))
      else $error("target outside unit range");

   // one item at a time: ready drops after a transfer
   one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   // reset leaves an empty, ready block
   after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind narma_target_generator narma_checker u_narma_checker (.*);

`default_nettype wire

FILE: tb/tb_narma_target_generator.sv
// self-checking testbench for the narma target generator with a scoreboard class
module tb_narma_target_generator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 12;
   localparam int PRINT_LIMIT     = 20;
   localparam int TANH_SPAN       = 65536;
   localparam int MAX_ORDER       = narma_pkg::MAX_ORDER;
   localparam int TBL_ENTRIES     = narma_pkg::TANH_TABLE_ENTRIES;
   localparam int Q14_ONE         = narma_pkg::Q14_ONE;
   localparam int SAMPLE_W        = narma_pkg::SAMPLE_WIDTH;
   localparam int TARGET_W        = narma_pkg::TARGET_WIDTH;

   typedef logic signed [SAMPLE_W-1:0]                 sample_word_type;
   typedef logic [narma_pkg::CSR_DATA_WIDTH-1:0]       csr_word_type;

   typedef struct {
      logic signed [TARGET_W-1:0] target;
      logic                       warming;
   } target_result_type;

   // recurrence predictor and in-order result checker
   class narma_target_scoreboard;
      int unsigned       order_n;
      int unsigned       alpha_w;
      int unsigned       beta_w;
      int unsigned       gamma_w;
      int                scaled_hist [MAX_ORDER];
      int                target_hist [MAX_ORDER];
      int                window_total;
      int unsigned       seen_count;
      int unsigned       ring_slot;
      longint unsigned   tanh_lut [TBL_ENTRIES+1];
      target_result_type expected_targets [$];
      int                error_count;

      function new();
         build_tanh_lut();
         order_n     = narma_pkg::ORDER_RESET;
         alpha_w     = narma_pkg::ALPHA_RESET;
         beta_w      = narma_pkg::BETA_RESET;
         gamma_w     = narma_pkg::GAMMA_RESET;
         error_count = 0;
         restart_series();
      endfunction

      function void restart_series();
         seen_count   = 0;
         window_total = 0;
         ring_slot    = 0;
      endfunction

      // tanh(4k/E) as (1-w)/(1+w), w = exp(-k/E)^8 from a taylor series in q.30
      function void build_tanh_lut();
         longint unsigned q_one;
         longint unsigned arg;
         longint unsigned term;
         longint unsigned w;
         longint          series;
         q_one = 64'd1 << 30;
         for (int k = 0; k <= TBL_ENTRIES; k++) begin
            arg    = (longint'(k) << 30) / TBL_ENTRIES;
            term   = q_one;
            series = longint'(q_one);
            for (int i = 1; i <= 20; i++) begin
               term = ((term * arg) >> 30) / i;
               if (i % 2 == 1) begin
                  series = series - longint'(term);
               end else begin
                  series = series + longint'(term);
               end
            end
            if (series < 0) begin
               series = 0;
            end
            w = series;
            repeat (3) w = (w * w + (q_one >> 1)) >> 30;
            if (w > q_one) begin
               w = q_one;
            end
            tanh_lut[k] = ((q_one - w) * 32768 + (q_one + w)) / (2 * (q_one + w));
         end
      endfunction

      // interpolated table tanh, saturating beyond 4.0
      function longint tanh_fix(longint x);
         longint unsigned mag;
         longint unsigned pos;
         longint unsigned idx;
         longint unsigned frac;
         longint unsigned lo;
         longint unsigned hi;
         longint unsigned diff;
         longint          r;
         mag = (x < 0) ? -x : x;
         if (mag >= TANH_SPAN) begin
            r = tanh_lut[TBL_ENTRIES];
         end else begin
            pos  = mag * TBL_ENTRIES;
            idx  = pos >> 16;
            frac = pos & 64'hFFFF;
            lo   = tanh_lut[idx];
            hi   = tanh_lut[idx + 1];
            diff = (hi > lo) ? hi - lo : 0;
            r    = lo + ((diff * frac + 32768) >> 16);
         end
         return (x < 0) ? -r : r;
      endfunction

      function void write_register(narma_pkg::csr_index_type idx, csr_word_type data);
         int unsigned req_order;
         case (idx)
            narma_pkg::CSR_ORDER: begin
               req_order = data[narma_pkg::ORDER_FIELD_WIDTH-1:0];
               if (req_order < narma_pkg::MIN_ORDER) begin
                  req_order = narma_pkg::MIN_ORDER;
               end else if (req_order > MAX_ORDER) begin
                  req_order = MAX_ORDER;
               end
               order_n = req_order;
               restart_series();
            end
            narma_pkg::CSR_ALPHA: alpha_w = data[narma_pkg::COEF_WIDTH-1:0];
            narma_pkg::CSR_BETA:  beta_w  = data[narma_pkg::COEF_WIDTH-1:0];
            narma_pkg::CSR_GAMMA: gamma_w = data[narma_pkg::COEF_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // advance the recurrence by one sample and queue the target it gives
      function void predict_target(sample_word_type raw, logic closes_series);
         int          u;
         int          scaled;
         int          y;
         int unsigned slot;
         int unsigned oldest;
         int unsigned newest;
         bit          warm;
         longint      y1;
         longint      delta;
         longint      acc;
         longint      v;
         target_result_type res;
         u = raw;
         if (u > Q14_ONE) begin
            u = Q14_ONE;
         end else if (u < -Q14_ONE) begin
            u = -Q14_ONE;
         end
         scaled = (u + Q14_ONE) >>> 2;
         slot   = ring_slot;
         oldest = (slot + MAX_ORDER - order_n) % MAX_ORDER;
         newest = (slot + MAX_ORDER - 1) % MAX_ORDER;
         warm   = seen_count < order_n;
         y      = 0;
         if (!warm) begin
            y1    = target_hist[newest];
            delta = (order_n >= narma_pkg::TANH_FROM_ORDER) ? narma_pkg::DELTA_HIGH_ORDER
                                                            : narma_pkg::DELTA_LOW_ORDER;
            acc   = longint'(alpha_w) * y1 * 16384
                  + longint'(beta_w) * y1 * longint'(window_total)
                  + longint'(gamma_w) * longint'(scaled_hist[oldest]) * longint'(scaled)
                  + (delta <<< 28);
            // q.42 back to q2.14, half up
            v = (acc + (longint'(1) <<< 27)) >>> 28;
            if (order_n >= narma_pkg::TANH_FROM_ORDER) begin
               v = tanh_fix(v);
            end
            if (v > Q14_ONE) begin
               v = Q14_ONE;
            end else if (v < -Q14_ONE) begin
               v = -Q14_ONE;
            end
            y = int'(v);
            window_total = window_total + y - target_hist[oldest];
         end else begin
            seen_count++;
         end
         scaled_hist[slot] = scaled;
         target_hist[slot] = y;
         ring_slot = (slot + 1) % MAX_ORDER;
         if (closes_series) begin
            restart_series();
         end
         res.target  = TARGET_W'(y);
         res.warming = warm;
         expected_targets = {expected_targets, res};
      endfunction

      task report(string msg);
         if (error_count < PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $time, msg);
         end
         error_count++;
      endtask

      task check(logic signed [TARGET_W-1:0] target, logic warming);
         target_result_type exp_res;
         if (expected_targets.size() == 0) begin
            report($sformatf("unexpected result target_out=%0d", target));
            return;
         end
         exp_res = expected_targets.pop_front();
         if (target !== exp_res.target) begin
            report($sformatf("target_out %0d, predicted %0d", target, exp_res.target));
         end
         if (warming !== exp_res.warming) begin
            report($sformatf("warming_up %b, predicted %b", warming, exp_res.warming));
         end
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   sample_word_type            req_sample_in;
   logic                       req_last_in_series;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [TARGET_W-1:0] rsp_target_out;
   logic                       rsp_warming_up;
   logic                       csr_write_en;
   narma_pkg::csr_index_type   csr_index;
   csr_word_type               csr_wdata;

   narma_target_scoreboard sb = new();

   int unsigned send_idle_pct = 35;
   int unsigned recv_idle_pct = 69;
   int          pressure_req  = 0;
   int          pressure_done = 0;
   int          quiet_cycles  = 0;

   narma_target_generator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_in      (req_sample_in),
      .req_last_in_series (req_last_in_series),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_target_out     (rsp_target_out),
      .rsp_warming_up     (rsp_warming_up),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: random stalls plus a long hold-off on request
   initial begin
      int hold;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_done != pressure_req) begin
            hold = HOLD_OFF_CYCLES;
            pressure_done++;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // result transfers go to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check(rsp_target_out, rsp_warming_up);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
         $display("narma_target_generator: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic sample_word_type pick_sample();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
         return SAMPLE_W'(int'($urandom_range(0, 2 * Q14_ONE)) - Q14_ONE);
      end else if (roll < 88) begin
         case ($urandom_range(0, 2))
            0:       return SAMPLE_W'(-Q14_ONE);
            1:       return SAMPLE_W'(Q14_ONE);
            default: return '0;
         endcase
      end
      // anything the port allows, clamped by the block
      return SAMPLE_W'($urandom);
   endfunction

   // one sample transfer, with random gaps ahead of it
   task automatic send_item(sample_word_type smp, logic closes_series);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sample_in      <= smp;
      req_last_in_series <= closes_series;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.predict_target(smp, closes_series);
   endtask

   task automatic put_csr(narma_pkg::csr_index_type idx, csr_word_type data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   // wait for every predicted target, then let the pipeline finish writeback
   task automatic settle();
      while (sb.expected_targets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(csr_word_type order_word, csr_word_type a, csr_word_type b,
                            csr_word_type g);
      settle();
      put_csr(narma_pkg::CSR_ORDER, order_word);
      put_csr(narma_pkg::CSR_ALPHA, a);
      put_csr(narma_pkg::CSR_BETA, b);
      put_csr(narma_pkg::CSR_GAMMA, g);
      csr_write_en <= 1'b0;
   endtask

   // mostly complete series with random content, some cut short or ended early
   task automatic run_series(int items, int unsigned s_pct, int unsigned r_pct,
                             int pressure_at);
      int   sent;
      int   len;
      logic closes_series;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, sb.order_n);
         end else begin
            len = $urandom_range(sb.order_n + 1, 3 * sb.order_n + 8);
         end
         for (int k = 0; k < len && sent < items; k++) begin
            closes_series = (k == len - 1) || ($urandom_range(0, 99) == 0);
            if (sent == pressure_at) begin
               pressure_req++;
            end
            send_item(pick_sample(), closes_series);
            sent++;
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      sample_word_type edge_samples [12];
      edge_samples = '{-16384, 16384, 16384, -16384, 0, 16'sh7FFF, 16'sh8000,
                       16383, -16383, 1, -1, 16385};
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_sample_in      <= '0;
      req_last_in_series <= 1'b0;
      csr_write_en       <= 1'b0;
      csr_index          <= narma_pkg::CSR_ORDER;
      csr_wdata          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // order below range with junk upper bits, all coefficients at maximum
      configure({8'hFF, 7'd0}, 15'h7FFF, 15'h7FFF, 15'h7FFF);
      for (int k = 0; k < 12; k++) begin
         send_item(edge_samples[k], k == 11);
      end
      req_valid <= 1'b0;

      // first order on the tanh path, default coefficients
      configure(15'd11, narma_pkg::ALPHA_RESET, narma_pkg::BETA_RESET,
                narma_pkg::GAMMA_RESET);
      for (int k = 0; k < 13; k++) begin
         send_item((k % 2) ? SAMPLE_W'(-Q14_ONE) : SAMPLE_W'(Q14_ONE), k == 12);
      end
      req_valid <= 1'b0;

      // random phases over several settings
      configure({8'($urandom), 7'd10}, narma_pkg::ALPHA_RESET, narma_pkg::BETA_RESET,
                narma_pkg::GAMMA_RESET);
      run_series(280, 35, 69, -1);
      configure(15'd65, 15'h7FFF, 15'h7FFF, 15'h7FFF);
      run_series(280, 69, 35, -1);
      configure(15'd1, 15'h0000, 15'h0000, 15'h0000);
      run_series(280, 0, 0, -1);
      configure(15'd11, 15'($urandom), 15'($urandom), 15'($urandom));
      run_series(280, 35, 69, -1);
      configure(15'd127, 15'($urandom_range(0, 16383)), 15'($urandom_range(0, 2047)),
                15'($urandom_range(0, 32767)));
      run_series(280, 69, 35, -1);
      configure({8'($urandom), 7'($urandom_range(narma_pkg::MIN_ORDER, MAX_ORDER))},
                15'($urandom), 15'($urandom_range(0, 4095)), 15'($urandom));
      run_series(280, 0, 0, 100);

      settle();
      if (sb.error_count == 0) begin
         $display("narma_target_generator: match");
      end else begin
         $display("narma_target_generator: mismatch");
      end
      $finish;
   end

endmodule
